// ===== src/wbep_pkg.sv =====
package wbep_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int OFFSET_BITS = 48;
    localparam int LEN_W       = 48;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int HDR_BYTES   = 64;

    localparam logic [31:0] ENTRY_MAGIC = 32'hdeadbeef;

    // byte positions inside an entry header
    localparam logic [5:0] K_MAGIC_LAST = 6'd3;
    localparam logic [5:0] K_LEN_FIRST  = 6'd8;
    localparam logic [5:0] K_OFF_FIRST  = 6'd16;
    localparam logic [5:0] K_OFF_LAST   = 6'd23;
    localparam logic [5:0] K_HDR_LAST   = 6'd63;

    // byte positions inside the file header
    localparam logic [LEN_W-1:0] F_COUNT_LAST = LEN_W'(3);
    localparam logic [LEN_W-1:0] F_HDR_LAST   = LEN_W'(HDR_BYTES - 1);

    typedef enum logic [3:0] {
        PH_FILE = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SLOT   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_TOO_SMALL   = 3'd0;
    localparam logic [2:0] ERR_BAD_COUNT   = 3'd1;
    localparam logic [2:0] ERR_HDR_PAST    = 3'd2;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd3;
    localparam logic [2:0] ERR_BAD_OFFSET  = 3'd4;
    localparam logic [2:0] ERR_DATA_PAST   = 3'd5;
    localparam logic [2:0] ERR_NOT_TILED   = 3'd6;

    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] entry_index;
        logic [LEN_W-1:0] slot_offset;
        logic [LEN_W-1:0] slot_length;
        logic [2:0]       error_code;
    } result_t;

endpackage

// ===== src/wbep_parser_core.sv =====
module wbep_parser_core
    import wbep_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_accept,
    input  logic [7:0]       byte_in,
    input  logic             cfg_write,
    input  logic [LEN_W-1:0] cfg_length,
    output logic             res_valid,
    output result_t          res
);

    logic [LEN_W-1:0] blob_reg;
    logic [LEN_W-1:0] pos_reg,      pos_next;
    phase_t           phase_reg,    phase_next;
    logic [LEN_W-1:0] expect_reg,   expect_next;
    logic [LEN_W-1:0] room_reg,     room_next;
    logic [5:0]       k_reg,        k_next;
    logic [CNT_W-1:0] seen_reg,     seen_next;
    logic [CNT_W-1:0] expected_reg, expected_next;
    logic [31:0]      magic_reg,    magic_next;
    logic [63:0]      len_reg,      len_next;
    logic [63:0]      off_reg,      off_next;
    logic [LEN_W-1:0] rem_reg,      rem_next;

    logic             emit;
    result_t          res_c;
    logic             do_end;
    logic [LEN_W:0]   pos_inc;
    logic [LEN_W:0]   pos_hdr_end;
    logic [CNT_W-1:0] seen_inc;

    assign pos_inc     = {1'b0, pos_reg} + (LEN_W+1)'(1);
    // start of the next entry header plus its size
    assign pos_hdr_end = {1'b0, pos_reg} + (LEN_W+1)'(HDR_BYTES + 1);
    assign seen_inc    = seen_reg + CNT_W'(1);

    always_comb begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        expect_next   = expect_reg;
        room_next     = room_reg;
        k_next        = k_reg;
        seen_next     = seen_reg;
        expected_next = expected_reg;
        magic_next    = magic_reg;
        len_next      = len_reg;
        off_next      = off_reg;
        rem_next      = rem_reg;
        emit          = 1'b0;
        do_end        = 1'b0;
        res_c         = '0;

        case (phase_reg)
            PH_FILE: begin
                pos_next = pos_reg + LEN_W'(1);
                if (pos_reg == '0 && blob_reg < LEN_W'(HDR_BYTES)) begin
                    emit             = 1'b1;
                    res_c.kind       = KIND_REJECT;
                    res_c.error_code = ERR_TOO_SMALL;
                    phase_next       = PH_DONE;
                end else begin
                    if (pos_reg < LEN_W'(4)) begin
                        magic_next[{pos_reg[1:0], 3'b000} +: 8] = byte_in;
                    end
                    if (pos_reg == F_COUNT_LAST) begin
                        if (magic_next == '0 || magic_next > 32'(MAX_ENTRIES)) begin
                            emit             = 1'b1;
                            res_c.kind       = KIND_REJECT;
                            res_c.error_code = ERR_BAD_COUNT;
                            phase_next       = PH_DONE;
                        end else begin
                            expected_next = magic_next[CNT_W-1:0];
                        end
                    end
                    if (pos_reg == F_HDR_LAST) begin
                        // first entry header must fit
                        if ({1'b0, expect_reg} > {1'b0, blob_reg}) begin
                            emit              = 1'b1;
                            res_c.kind        = KIND_REJECT;
                            res_c.entry_index = seen_reg[IDX_W-1:0];
                            res_c.error_code  = ERR_HDR_PAST;
                            phase_next        = PH_DONE;
                        end else begin
                            phase_next = PH_HDR;
                            magic_next = '0;
                            len_next   = '0;
                            off_next   = '0;
                            k_next     = '0;
                        end
                    end
                end
            end

            PH_HDR: begin
                pos_next = pos_reg + LEN_W'(1);
                k_next   = k_reg + 6'd1;
                if (k_reg == '0) begin
                    room_next = blob_reg - expect_reg;
                end
                if (k_reg <= K_MAGIC_LAST) begin
                    magic_next[{k_reg[1:0], 3'b000} +: 8] = byte_in;
                    if (k_reg == K_MAGIC_LAST && magic_next != ENTRY_MAGIC) begin
                        emit              = 1'b1;
                        res_c.kind        = KIND_REJECT;
                        res_c.entry_index = seen_reg[IDX_W-1:0];
                        res_c.error_code  = ERR_BAD_MAGIC;
                        phase_next        = PH_DONE;
                    end
                end else if (k_reg >= K_LEN_FIRST && k_reg < K_OFF_FIRST) begin
                    len_next[{k_reg[2:0], 3'b000} +: 8] = byte_in;
                end else if (k_reg >= K_OFF_FIRST && k_reg <= K_OFF_LAST) begin
                    off_next[{k_reg[2:0], 3'b000} +: 8] = byte_in;
                    if (k_reg == K_OFF_LAST) begin
                        if (off_next != 64'(expect_reg)) begin
                            emit              = 1'b1;
                            res_c.kind        = KIND_REJECT;
                            res_c.entry_index = seen_reg[IDX_W-1:0];
                            res_c.error_code  = ERR_BAD_OFFSET;
                            phase_next        = PH_DONE;
                        end else if ((len_reg >> OFFSET_BITS) != '0 ||
                                     len_reg[LEN_W-1:0] > room_reg) begin
                            emit              = 1'b1;
                            res_c.kind        = KIND_REJECT;
                            res_c.entry_index = seen_reg[IDX_W-1:0];
                            res_c.error_code  = ERR_DATA_PAST;
                            phase_next        = PH_DONE;
                        end else begin
                            rem_next          = len_reg[LEN_W-1:0];
                            emit              = 1'b1;
                            res_c.kind        = KIND_SLOT;
                            res_c.entry_index = seen_reg[IDX_W-1:0];
                            res_c.slot_offset = expect_reg;
                            res_c.slot_length = len_reg[LEN_W-1:0];
                        end
                    end
                end
                if (k_reg == K_HDR_LAST) begin
                    if (rem_reg == '0) begin
                        do_end = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end

            PH_DATA: begin
                pos_next = pos_reg + LEN_W'(1);
                if (rem_reg != '0) begin
                    rem_next = rem_reg - LEN_W'(1);
                end
                if (rem_next == '0) begin
                    do_end = 1'b1;
                end
            end

            default: begin
            end
        endcase

        if (do_end) begin
            seen_next = seen_inc;
            if (seen_inc >= expected_reg) begin
                emit       = 1'b1;
                phase_next = PH_DONE;
                if (pos_inc == {1'b0, blob_reg}) begin
                    res_c.kind = KIND_ACCEPT;
                end else begin
                    res_c.kind       = KIND_REJECT;
                    res_c.error_code = ERR_NOT_TILED;
                end
            end else if (pos_hdr_end > {1'b0, blob_reg}) begin
                emit              = 1'b1;
                res_c.kind        = KIND_REJECT;
                res_c.entry_index = seen_inc[IDX_W-1:0];
                res_c.error_code  = ERR_HDR_PAST;
                phase_next        = PH_DONE;
            end else begin
                phase_next  = PH_HDR;
                expect_next = pos_hdr_end[LEN_W-1:0];
                magic_next  = '0;
                len_next    = '0;
                off_next    = '0;
                k_next      = '0;
            end
        end
    end

    assign res_valid = byte_accept && emit;
    assign res       = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blob_reg     <= LEN_W'(1);
            pos_reg      <= '0;
            phase_reg    <= PH_FILE;
            expect_reg   <= LEN_W'(2 * HDR_BYTES);
            k_reg        <= '0;
            seen_reg     <= '0;
            expected_reg <= '0;
            magic_reg    <= '0;
            len_reg      <= '0;
            off_reg      <= '0;
            rem_reg      <= '0;
        end else if (cfg_write) begin
            // new length restarts the parse
            blob_reg     <= cfg_length;
            pos_reg      <= '0;
            phase_reg    <= PH_FILE;
            expect_reg   <= LEN_W'(2 * HDR_BYTES);
            k_reg        <= '0;
            seen_reg     <= '0;
            expected_reg <= '0;
            magic_reg    <= '0;
            len_reg      <= '0;
            off_reg      <= '0;
            rem_reg      <= '0;
        end else if (byte_accept) begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            expect_reg   <= expect_next;
            k_reg        <= k_next;
            seen_reg     <= seen_next;
            expected_reg <= expected_next;
            magic_reg    <= magic_next;
            len_reg      <= len_next;
            off_reg      <= off_next;
            rem_reg      <= rem_next;
        end
    end

    // data room of the current entry, refreshed at its first header byte
    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            room_reg <= room_next;
        end
    end

endmodule

// ===== src/wbep_out_queue.sv =====
module wbep_out_queue
    import wbep_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    not_full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] count_reg, count_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 2'd0;
    assign not_full  = count_reg != 2'd2;
    assign out_data  = head_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            head_reg <= (count_reg == 2'd2) ? tail_reg : push_data;
        end else if (count_reg == 2'd0) begin
            head_reg <= push_data;
        end
        // second word only fills behind a stalled head
        if (push && !pop && count_reg == 2'd1) begin
            tail_reg <= push_data;
        end
    end

endmodule

// ===== src/weight_blob_entry_parser.sv =====
// Weight blob entry parser. Streams a weight blob in one byte per word on the
// s_ side and checks its file header, entry headers and data tiling against
// blob_length, written beforehand on the cfg_ port (a write also restarts the
// parse). Each good entry yields a slot word on the m_ side, and the run ends
// with one accept or one reject word; bytes after that are taken and dropped.
// A byte is taken every cycle while s_tready is high; its result, if any, is
// registered in the cycle it is accepted and shows on m_ behind any earlier words. A
// two-word output buffer keeps input flowing while a result waits; s_tready
// drops only while both buffer words are held by a stalled m_ side.
module weight_blob_entry_parser
    import wbep_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [47:0]  cfg_data,    // blob_length
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,     // entry_index, slot_offset, slot_length, error_code
    output logic [1:0]   m_tuser      // result_kind
);

    logic    byte_accept;
    logic    res_valid;
    result_t res;
    result_t head;
    logic    not_full;

    assign cfg_ready   = 1'b1;
    assign s_tready    = not_full;
    assign byte_accept = s_tvalid && s_tready;

    wbep_parser_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .byte_in     (s_tdata),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_length  (cfg_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    wbep_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .not_full  (not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {1'b0, head.error_code, head.slot_length, head.slot_offset,
                      head.entry_index};
    assign m_tuser = head.kind;

endmodule

// ===== src/wbep_checker.sv =====
module wbep_checker
    import wbep_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [47:0]  cfg_data,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [7:0]   s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // input stalls only behind held results
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_non_slot_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_SLOT |-> m_tdata[107:12] == '0)
        else $error("slot fields set on a non-slot word");

    a_reject_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REJECT |-> m_tdata[110:108] != 3'd7)
        else $error("reject word with invalid error code");

endmodule

bind weight_blob_entry_parser wbep_checker u_checker (.*);
